[hdl/serial_command_frame_parser_assert.svh]
// ----------------------------------------------------------------------------
// Serial command frame parser assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_FRAME_PARSER_ASSERT_SVH
`define SERIAL_COMMAND_FRAME_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF

`define SCFP_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("serial command frame parser assertion failed");

`define SCFP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("serial command frame parser assertion failed");

`else

`define SCFP_ASSERT(label, prop)

`define SCFP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[hdl/scfp_pkg.sv]
// ----------------------------------------------------------------------------
// Serial command frame parser package
// Result kinds, character codes and default sizes shared by the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package scfp_pkg;

	typedef enum logic [1:0] {
		KIND_STORED   = 2'd0,
		KIND_END      = 2'd1,
		KIND_FORMAT   = 2'd2,
		KIND_OVERFLOW = 2'd3
	} kind_t;

	localparam int DEF_BUFFER_BYTES  = 512;
	localparam int DEF_LENGTH_DIGITS = 3;

	localparam int IDX_MAX_W = 10;
	localparam int LEN_W     = 10;
	localparam int PCNT_W    = 10;
	localparam int POS_W     = 9;
	localparam int CMP_W     = 17;
	localparam int ACC_W     = 14;

	localparam logic [7:0]       CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0]       CHAR_COMMA   = 8'h2C;
	localparam logic [7:0]       CHAR_ZERO    = 8'h30;
	localparam logic [7:0]       CHAR_NINE    = 8'h39;
	localparam logic [7:0]       CHAR_W       = 8'h57;
	localparam logic [15:0]      PREFIX_SO    = 16'h534F;
	localparam logic [LEN_W-1:0] LEN_MAX      = 10'd1023;
	localparam logic [1:0]       COMMAS_ALL   = 2'd3;
	localparam logic [1:0]       COMMAS_LEN   = 2'd2;

endpackage

`default_nettype wire

[hdl/serial_command_frame_parser.sv]
// ----------------------------------------------------------------------------
// Serial command frame parser
// Frames received serial bytes into lines and checks "SOW" data frames.
// The s_ channel takes one received byte per transaction. The m_ channel
// gives one result per byte: tuser holds the kind (byte stored, frame end,
// missing terminator, buffer overflow) and tdata the stored byte, its
// position, the data frame flag and the declared payload length.
// A byte passes an input register and then a result register. One byte is
// taken in every cycle while the receiver takes results, since each byte
// only updates a handful of counters and flags. Reset clears the frame
// state and the valid flags of both registers. When the receiver stalls,
// the result register holds and s_tready drops as soon as the input
// register also holds a byte.
// ----------------------------------------------------------------------------
`default_nettype none
`include "serial_command_frame_parser_assert.svh"

module serial_command_frame_parser #(
	parameter int BUFFER_BYTES  = scfp_pkg::DEF_BUFFER_BYTES,
	parameter int LENGTH_DIGITS = scfp_pkg::DEF_LENGTH_DIGITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // [7:0] stored_byte, [16:8] byte_position,
	                                   // [17] is_data_frame, [27:18] declared_length
	output logic [1:0]       m_tuser   // [1:0] result_kind
);

	import scfp_pkg::*;

	localparam int IDX_W   = ($clog2(BUFFER_BYTES) > IDX_MAX_W) ? IDX_MAX_W
	                         : $clog2(BUFFER_BYTES);
	localparam int DIGIT_W = $clog2(LENGTH_DIGITS + 1);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              valid_s2;
	kind_t             kind_s2;
	logic [7:0]        stored_s2;
	logic [POS_W-1:0]  pos_s2;
	logic              flag_s2;
	logic [LEN_W-1:0]  len_s2;

	logic [IDX_W-1:0]   idx_q;
	logic [15:0]        prefix_q;
	logic               flag_q;
	logic [1:0]         comma_q;
	logic [DIGIT_W-1:0] dcnt_q;
	logic               stop_q;
	logic [LEN_W-1:0]   len_q;
	logic [PCNT_W-1:0]  pcnt_q;
	logic               phase_q;

	logic [IDX_W-1:0]   idx_d;
	logic [15:0]        prefix_d;
	logic               flag_d;
	logic [1:0]         comma_d;
	logic [DIGIT_W-1:0] dcnt_d;
	logic               stop_d;
	logic [LEN_W-1:0]   len_d;
	logic [PCNT_W-1:0]  pcnt_d;
	logic               phase_d;

	kind_t              kind_d;
	logic [7:0]         stored_d;
	logic               flag_n;
	logic [LEN_W-1:0]   len_n;
	logic               store;
	logic               done;
	logic               is_digit;
	logic [ACC_W-1:0]   acc;
	logic [CMP_W-1:0]   pos_next;
	logic [31:0]        pos_wide;
	logic               adv;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	assign is_digit = (byte_s1 >= CHAR_ZERO) && (byte_s1 <= CHAR_NINE);
	assign acc      = {len_q, 3'b000} + {1'b0, len_q, 1'b0} + ACC_W'(byte_s1 - CHAR_ZERO);
	assign pos_next = CMP_W'(idx_q) + CMP_W'(1);
	assign pos_wide = 32'(idx_q);

	always_comb begin
		prefix_d = prefix_q;
		flag_n   = flag_q;
		comma_d  = comma_q;
		dcnt_d   = dcnt_q;
		stop_d   = stop_q;
		len_n    = len_q;
		pcnt_d   = pcnt_q;
		phase_d  = phase_q;
		idx_d    = idx_q;
		kind_d   = KIND_STORED;
		stored_d = 8'h00;
		store    = 1'b0;
		done     = 1'b0;

		if (idx_q < IDX_W'(2)) begin
			prefix_d = {prefix_q[7:0], byte_s1};
		end
		if (idx_q == IDX_W'(2)) begin
			flag_n = (prefix_q == PREFIX_SO) && (byte_s1 == CHAR_W);
		end

		if (flag_n && !phase_q) begin
			if (byte_s1 == CHAR_COMMA) begin
				if (comma_q != COMMAS_ALL) begin
					comma_d = comma_q + 2'd1;
				end
			end else if (comma_q == COMMAS_LEN && dcnt_q < DIGIT_W'(LENGTH_DIGITS)) begin
				dcnt_d = dcnt_q + DIGIT_W'(1);
				if (!stop_q) begin
					if (is_digit) begin
						len_n = (acc > ACC_W'(LEN_MAX)) ? LEN_MAX : acc[LEN_W-1:0];
					end else begin
						stop_d = 1'b1;
					end
				end
			end
		end

		if (phase_q) begin
			if (pcnt_q < len_n) begin
				store = 1'b1;
			end else begin
				kind_d = (byte_s1 == CHAR_NEWLINE) ? KIND_END : KIND_FORMAT;
				done   = 1'b1;
			end
		end else if (byte_s1 == CHAR_NEWLINE) begin
			kind_d = KIND_END;
			done   = 1'b1;
		end else begin
			store = 1'b1;
		end

		if (store) begin
			if (pos_next >= CMP_W'(BUFFER_BYTES)) begin
				kind_d = KIND_OVERFLOW;
				done   = 1'b1;
			end else begin
				kind_d   = KIND_STORED;
				stored_d = byte_s1;
				if (phase_q) begin
					pcnt_d = pcnt_q + PCNT_W'(1);
				end else if (flag_n && comma_d == COMMAS_ALL) begin
					phase_d = 1'b1;
				end
				idx_d = pos_next[IDX_W-1:0];
			end
		end

		flag_d = flag_n;
		len_d  = len_n;
		if (done) begin
			idx_d    = '0;
			prefix_d = '0;
			flag_d   = 1'b0;
			comma_d  = '0;
			dcnt_d   = '0;
			stop_d   = 1'b0;
			len_d    = '0;
			pcnt_d   = '0;
			phase_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			kind_s2  <= KIND_STORED;
			idx_q    <= '0;
			prefix_q <= '0;
			flag_q   <= 1'b0;
			comma_q  <= '0;
			dcnt_q   <= '0;
			stop_q   <= 1'b0;
			len_q    <= '0;
			pcnt_q   <= '0;
			phase_q  <= 1'b0;
		end else begin
			if (adv) begin
				valid_s2 <= 1'b1;
				kind_s2  <= kind_d;
				idx_q    <= idx_d;
				prefix_q <= prefix_d;
				flag_q   <= flag_d;
				comma_q  <= comma_d;
				dcnt_q   <= dcnt_d;
				stop_q   <= stop_d;
				len_q    <= len_d;
				pcnt_q   <= pcnt_d;
				phase_q  <= phase_d;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stored_s2 <= stored_d;
			pos_s2    <= pos_wide[POS_W-1:0];
			flag_s2   <= flag_n;
			len_s2    <= len_n;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = kind_s2;
	assign m_tdata  = {4'b0000, len_s2, flag_s2, pos_s2, stored_s2};

	`SCFP_ASSERT(a_phase_needs_frame, !phase_q || (flag_q && comma_q == COMMAS_ALL))
	`SCFP_ASSERT(a_payload_bounded, !phase_q || (pcnt_q <= len_q))
	`SCFP_ASSERT(a_index_in_buffer, 32'(idx_q) < BUFFER_BYTES)
	`SCFP_ASSERT(a_commas_need_frame, (comma_q == 2'd0) || flag_q)
	`SCFP_ASSERT_NEXT(a_clear_after_done, adv && (kind_d != KIND_STORED), idx_q == '0 && !phase_q)

endmodule

`default_nettype wire

[tb/serial_command_frame_parser_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command frame parser testbench
// Streams received bytes into the parser: a few hand-made lines first, then
// random data frames, plain lines, noise and a buffer overflow. Each accepted
// byte is parsed again by a model kept in a scoreboard. Every result
// transaction is checked against the oldest parse outcome still waiting.
// Both stream sides idle at random, except in the last phase.
// ----------------------------------------------------------------------------

module serial_command_frame_parser_tb;

	import scfp_pkg::*;

	localparam int FRAME_BYTES = DEF_BUFFER_BYTES;
	localparam int LEN_CHARS   = DEF_LENGTH_DIGITS;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  stored;
		logic [8:0]  pos;
		logic        data_frame;
		logic [9:0]  len;
	} parse_result_t;

	class frame_parse_board;
		parse_result_t awaited_results[$];
		int            mismatches;
		int            frame_index;
		logic [15:0]   command_prefix;
		logic          data_frame;
		int            comma_count;
		int            len_chars_seen;
		logic          len_ended;
		int            length_value;
		int            payload_count;
		logic          in_payload;

		function new();
			mismatches = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			frame_index    = 0;
			command_prefix = '0;
			data_frame     = 1'b0;
			comma_count    = 0;
			len_chars_seen = 0;
			len_ended      = 1'b0;
			length_value   = 0;
			payload_count  = 0;
			in_payload     = 1'b0;
		endfunction

		function void length_char(logic [7:0] b);
			int v;
			if (len_chars_seen >= LEN_CHARS)
				return;
			len_chars_seen++;
			if (len_ended)
				return;
			if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
				v = length_value * 10 + (int'(b) - int'(CHAR_ZERO));
				length_value = (v > int'(LEN_MAX)) ? int'(LEN_MAX) : v;
			end else begin
				len_ended = 1'b1;
			end
		endfunction

		function parse_result_t parse_byte(logic [7:0] b);
			parse_result_t r;
			int            pos;
			bit            store;
			bit            done;
			r     = '0;
			pos   = frame_index;
			store = 1'b0;
			done  = 1'b0;
			if (pos < 2)
				command_prefix = {command_prefix[7:0], b};
			if (pos == 2)
				data_frame = (command_prefix == PREFIX_SO && b == CHAR_W);
			if (data_frame && !in_payload) begin
				if (b == CHAR_COMMA) begin
					if (comma_count < int'(COMMAS_ALL))
						comma_count++;
				end else if (comma_count == int'(COMMAS_LEN)) begin
					length_char(b);
				end
			end
			if (in_payload) begin
				if (payload_count < length_value) begin
					store = 1'b1;
				end else begin
					r.kind = (b == CHAR_NEWLINE) ? KIND_END : KIND_FORMAT;
					done   = 1'b1;
				end
			end else if (b == CHAR_NEWLINE) begin
				r.kind = KIND_END;
				done   = 1'b1;
			end else begin
				store = 1'b1;
			end
			if (store) begin
				if (pos + 1 >= FRAME_BYTES) begin
					r.kind = KIND_OVERFLOW;
					done   = 1'b1;
				end else begin
					r.kind   = KIND_STORED;
					r.stored = b;
					if (in_payload)
						payload_count++;
					else if (data_frame && comma_count == int'(COMMAS_ALL))
						in_payload = 1'b1;
					frame_index = pos + 1;
				end
			end
			r.pos        = pos[8:0];
			r.data_frame = data_frame;
			r.len        = length_value[9:0];
			if (done)
				clear_frame();
			return r;
		endfunction

		function void take_byte(logic [7:0] b);
			awaited_results.push_back(parse_byte(b));
		endfunction

		function void note_mismatch(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: mismatch: %s", $realtime, msg);
		endfunction

		function void check_result(logic [31:0] data, logic [1:0] user);
			parse_result_t got;
			parse_result_t want;
			got.kind       = kind_t'(user);
			got.stored     = data[7:0];
			got.pos        = data[16:8];
			got.data_frame = data[17];
			got.len        = data[27:18];
			if (awaited_results.size() == 0) begin
				note_mismatch($sformatf("unexpected result kind %0d byte %02h pos %0d flag %0b len %0d",
					got.kind, got.stored, got.pos, got.data_frame, got.len));
				return;
			end
			want = awaited_results.pop_front();
			if (got !== want)
				note_mismatch($sformatf({"expected kind %0d byte %02h pos %0d flag %0b len %0d, ",
					"got kind %0d byte %02h pos %0d flag %0b len %0d"},
					want.kind, want.stored, want.pos, want.data_frame, want.len,
					got.kind, got.stored, got.pos, got.data_frame, got.len));
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	frame_parse_board board = new();
	int               send_idle_pct = 21;
	int               recv_idle_pct = 53;
	int               bytes_sent = 0;

	serial_command_frame_parser #(
		.BUFFER_BYTES  (FRAME_BYTES),
		.LENGTH_DIGITS (LEN_CHARS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.check_result(m_tdata, m_tuser);
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	function automatic logic [7:0] pick_text_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CHAR_NEWLINE || b == CHAR_COMMA);
		return b;
	endfunction

	function automatic logic [7:0] pick_non_digit();
		logic [7:0] b;
		do
			b = pick_text_byte();
		while (b >= CHAR_ZERO && b <= CHAR_NINE);
		return b;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (!s_tready);
		board.take_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_random_frame();
		int    sel;
		int    n;
		int    len;
		string len_text;
		sel = $urandom_range(0, 99);
		if (sel < 80) begin
			len = $urandom_range(0, 24);
			case ($urandom_range(0, 3))
				0: len_text = $sformatf("%0d", len);
				1: len_text = $sformatf("%0d%c", len, pick_non_digit());
				2: begin
					len = len % 10;
					len_text = $sformatf("00%0d%0d", len, $urandom_range(0, 9));
				end
				default: begin
					len = 0;
					len_text = $sformatf("%c%0d", pick_non_digit(), $urandom_range(0, 99));
				end
			endcase
			send_text("SOW,");
			n = $urandom_range(0, 3);
			repeat (n)
				send_byte(pick_text_byte());
			send_byte(CHAR_COMMA);
			send_text(len_text);
			send_byte(CHAR_COMMA);
			repeat (len)
				send_byte(8'($urandom_range(0, 255)));
			if (sel < 70)
				send_byte(CHAR_NEWLINE);
			else
				send_byte(pick_text_byte());
		end else if (sel < 90) begin
			if ($urandom_range(0, 3) == 0)
				send_text("SO");
			n = $urandom_range(0, 15);
			repeat (n)
				send_byte(pick_text_byte());
			send_byte(CHAR_NEWLINE);
		end else begin
			n = $urandom_range(1, 12);
			repeat (n)
				send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int phase_start;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;

		send_text("SOW,,0,\n");
		send_text("SOW,a,1,x");
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(CHAR_NEWLINE);
		send_text("SO\n");

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 53 : 0;
			recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 21 : 0;
			if (phase == 0) begin
				send_text("SOW,,999,");
				repeat (505)
					send_byte(8'($urandom_range(0, 255)));
			end
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < 60)
				send_random_frame();
		end
		s_tvalid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (10)
			@(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
+incdir+hdl
hdl/scfp_pkg.sv
hdl/serial_command_frame_parser.sv
tb/serial_command_frame_parser_tb.sv
